FILE: rtl/tama_pkg.sv
package tama_pkg;

  // axes carried by one beat
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = $clog2(NUM_AXES);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } tama_state_e;

endpackage

FILE: rtl/three_axis_moving_average_unit.sv
// flow: an accepted beat updates ring and sums (ST_READ), then each axis is loaded
//   (ST_LOAD) and divided over TOT_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits (ST_DIV)
// no new beat is taken before the sequencer returns to ST_IDLE; the one bit-serial
//   divider is shared by the axes; a finished result waits in the output register
// reset: window length MAX_WINDOW (at most 32), sums, pointer and fill count cleared;
//   ring entries are not subtracted before the window fills, so no clearing pass is run
module three_axis_moving_average_unit #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]      window_length_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_y_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        mean_x_o,
  output logic signed [SAMPLE_BITS-1:0]        mean_y_o,
  output logic signed [SAMPLE_BITS-1:0]        mean_z_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0]      samples_held_o
);

  import tama_pkg::*;

  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int TOT_W      = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int STEP_W     = $clog2(TOT_W);
  localparam int WORD_W     = NUM_AXES * SAMPLE_BITS;
  localparam int WIN_RESET  = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;

  tama_state_e state_q, state_d;

  logic [CNT_W-1:0]              win_q;
  logic [CNT_W-1:0]              fill_q;
  logic [PTR_W-1:0]              ptr_q;
  logic signed [TOT_W-1:0]       total_q  [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] sample_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] mean_q   [NUM_AXES];
  logic [AXIS_W-1:0]             axis_q;
  logic [STEP_W-1:0]             step_q;
  logic [TOT_W-1:0]              dq_q;
  logic [CNT_W-1:0]              rem_q;
  logic                          neg_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [CNT_W-1:0]              out_held_q;

  logic                          in_ready;
  logic                          ram_re;
  logic                          ram_we;
  logic                          load_out;
  logic [WORD_W-1:0]             ram_wdata;
  logic [WORD_W-1:0]             ram_rdata;
  logic [CNT_W-1:0]              win_clamped;
  logic                          ring_full;
  logic [CNT_W-1:0]              ptr_inc;
  logic                          div_last;
  logic                          axis_last;

  // ring store, one word holds all three axes
  tama_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .we_i    (ram_we),
    .addr_i  (ptr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {sample_q[2], sample_q[1], sample_q[0]};

  // clamp written window length to 1..MAX_WINDOW
  always_comb begin
    win_clamped = window_length_i;
    if (window_length_i == '0) begin
      win_clamped = CNT_W'(1);
    end else if (window_length_i > CNT_W'(MAX_WINDOW)) begin
      win_clamped = CNT_W'(MAX_WINDOW);
    end
  end

  // slot holds a live sample only once the window has filled
  assign ring_full = (fill_q == win_q);
  assign ptr_inc   = CNT_W'(ptr_q) + CNT_W'(1);
  assign div_last  = (step_q == STEP_W'(TOT_W - 1));
  assign axis_last = (axis_q == AXIS_W'(NUM_AXES - 1));

  // next state and control
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          ram_re  = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_we  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = axis_last ? ST_OUT : ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window, pointer, fill count and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= CNT_W'(WIN_RESET);
      fill_q <= '0;
      ptr_q  <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        total_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      win_q  <= win_clamped;
      fill_q <= '0;
      ptr_q  <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        total_q[a] <= '0;
      end
    end else if (state_q == ST_READ) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        total_q[a] <= total_q[a]
                    - (ring_full ? TOT_W'($signed(ram_rdata[a*SAMPLE_BITS +: SAMPLE_BITS]))
                                 : TOT_W'(0))
                    + TOT_W'(sample_q[a]);
      end
      if (!ring_full) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      ptr_q <= (ptr_inc >= win_q) ? '0 : ptr_inc[PTR_W-1:0];
    end
  end

  // capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      sample_q[0] <= sample_x_i;
      sample_q[1] <= sample_y_i;
      sample_q[2] <= sample_z_i;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [TOT_W-1:0]  dq_nx;
  logic [CNT_W:0]    rem_sub;
  logic [TOT_W-1:0]  quot_signed;

  always_comb begin
    rem_sh      = {rem_q, dq_q[TOT_W-1]};
    rem_ge      = (rem_sh >= {1'b0, fill_q});
    rem_sub     = rem_sh - {1'b0, fill_q};
    dq_nx       = {dq_q[TOT_W-2:0], rem_ge};
    quot_signed = neg_q ? (~dq_nx + TOT_W'(1)) : dq_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      step_q <= '0;
    end else begin
      unique case (state_q)
        ST_READ: begin
          axis_q <= '0;
        end
        ST_LOAD: begin
          step_q <= '0;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (div_last) begin
            axis_q <= axis_q + AXIS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      neg_q <= total_q[axis_q][TOT_W-1];
      dq_q  <= total_q[axis_q][TOT_W-1] ? (~total_q[axis_q] + TOT_W'(1))
                                         : total_q[axis_q];
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      dq_q  <= dq_nx;
      rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      if (div_last) begin
        mean_q[axis_q] <= quot_signed[SAMPLE_BITS-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q    <= mean_q[0];
      out_y_q    <= mean_q[1];
      out_z_q    <= mean_q[2];
      out_held_q <= fill_q;
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign mean_x_o       = out_x_q;
  assign mean_y_o       = out_y_q;
  assign mean_z_o       = out_z_q;
  assign samples_held_o = out_held_q;

  // fill count never passes the window
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= win_q)
    else $error("fill count above window length");

  // while filling, pointer tracks fill count, so unwritten slots are never used
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != win_q) |-> (CNT_W'(ptr_q) == fill_q))
    else $error("ring pointer out of step with fill count");

  // every accepted beat is written to the ring in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ram_we)
    else $error("accepted beat not written back");

  // divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < fill_q))
    else $error("divider remainder out of range");

  // a result is only presented after a nonzero fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (samples_held_o != '0))
    else $error("result with empty window");

endmodule

FILE: rtl/tama_ram.sv
module tama_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: test/three_axis_moving_average_unit_test.sv
`timescale 1ns / 1ps

module three_axis_moving_average_unit_test;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int TARGET_BEATS = 1850;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE_CYCLES = 4;
  localparam int FINAL_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 3_000_000;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0] S_MIN = 16'h8000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } axis_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean_x;
    logic signed [SAMPLE_BITS-1:0] mean_y;
    logic signed [SAMPLE_BITS-1:0] mean_z;
    logic [LEN_W-1:0]              held;
  } mean_beat_t;

  typedef enum int {
    MIX_WIDE,
    RAIL_HIGH,
    RAIL_LOW,
    NEAR_ZERO
  } sample_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [LEN_W-1:0]              window_length_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_x_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_y_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_z_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mean_x_o;
  logic signed [SAMPLE_BITS-1:0] mean_y_o;
  logic signed [SAMPLE_BITS-1:0] mean_z_o;
  logic [LEN_W-1:0]              samples_held_o;

  three_axis_moving_average_unit #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .window_length_i (window_length_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_x_i      (sample_x_i),
    .sample_y_i      (sample_y_i),
    .sample_z_i      (sample_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mean_x_o        (mean_x_o),
    .mean_y_o        (mean_y_o),
    .mean_z_o        (mean_z_o),
    .samples_held_o  (samples_held_o)
  );

  // shared between stimulus, driver and monitor
  axis_beat_t pending_beats[$];
  mean_beat_t expected_means[$];
  int         error_count = 0;
  int         beats_queued = 0;
  int         means_seen = 0;
  int         holds_asked = 0;
  bit         idle_on = 1'b1;

  // predictor copy of the filter history
  logic signed [SAMPLE_BITS-1:0] history [3][MAX_WINDOW];
  longint                        axis_sum [3];
  int                            slot_ptr;
  int                            held_count;
  int                            window_len;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // new window length: clamp into 1..MAX_WINDOW and forget all history
  function automatic void restart_history(input logic [LEN_W-1:0] len);
    if (len == 0) window_len = 1;
    else if (len > MAX_WINDOW) window_len = MAX_WINDOW;
    else window_len = len;
    for (int a = 0; a < 3; a++) begin
      axis_sum[a] = 0;
      for (int i = 0; i < MAX_WINDOW; i++) history[a][i] = '0;
    end
    slot_ptr   = 0;
    held_count = 0;
  endfunction

  // push one sample through the window, return the averages it yields
  function automatic mean_beat_t advance_average(input axis_beat_t s);
    mean_beat_t                    r;
    logic signed [SAMPLE_BITS-1:0] v [3];
    longint                        q [3];
    v[0] = s.x;
    v[1] = s.y;
    v[2] = s.z;
    if (held_count < window_len) held_count++;
    for (int a = 0; a < 3; a++) begin
      axis_sum[a] -= history[a][slot_ptr];
      history[a][slot_ptr] = v[a];
      axis_sum[a] += v[a];
      q[a] = axis_sum[a] / longint'(held_count);
    end
    slot_ptr = (slot_ptr + 1 >= window_len) ? 0 : slot_ptr + 1;
    r.mean_x = SAMPLE_BITS'(q[0]);
    r.mean_y = SAMPLE_BITS'(q[1]);
    r.mean_z = SAMPLE_BITS'(q[2]);
    r.held   = LEN_W'(held_count);
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      RAIL_HIGH: return (r < 85) ? S_MAX : SAMPLE_BITS'($urandom());
      RAIL_LOW:  return (r < 85) ? S_MIN : SAMPLE_BITS'($urandom());
      NEAR_ZERO: return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: begin
        if (r < 10) return S_MIN;
        if (r < 20) return S_MAX;
        if (r < 35) return SAMPLE_BITS'($urandom_range(0, 6) - 3);
        return SAMPLE_BITS'($urandom());
      end
    endcase
  endfunction

  function automatic void compare_field(input string tag, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
      error_count++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin : drive_samples
    axis_beat_t next_beat;
    bit         taken;
    int         send_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        expected_means.push_back(
          advance_average(axis_beat_t'{sample_x_i, sample_y_i, sample_z_i}));
      end
      if (!in_valid_i || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat  = pending_beats.pop_front();
          sample_x_i <= next_beat.x;
          sample_y_i <= next_beat.y;
          sample_z_i <= next_beat.z;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with receiver stalls
  always @(posedge clk_i) begin : watch_means
    mean_beat_t want;
    int         hold_off;
    int         holds_served;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_off = 0;
      holds_served = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        means_seen++;
        if (expected_means.size() == 0) begin
          $display("%0t: mean beat with nothing expected, actual %0d %0d %0d held %0d",
                   $time, mean_x_o, mean_y_o, mean_z_o, samples_held_o);
          error_count++;
        end else begin
          want = expected_means.pop_front();
          compare_field("mean_x", want.mean_x, mean_x_o);
          compare_field("mean_y", want.mean_y, mean_y_o);
          compare_field("mean_z", want.mean_z, mean_z_o);
          compare_field("samples_held", want.held, samples_held_o);
        end
        hold_off = pick_gap();
      end else if (hold_off == 0 && $urandom_range(0, 99) < 3) begin
        hold_off = pick_gap();
      end
      // long back-pressure stretch on request
      if (hold_off == 0 && holds_served < holds_asked) begin
        holds_served++;
        hold_off = LONG_HOLD;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void queue_beat(input logic [SAMPLE_BITS-1:0] x,
                                     input logic [SAMPLE_BITS-1:0] y,
                                     input logic [SAMPLE_BITS-1:0] z);
    pending_beats.push_back(axis_beat_t'{x, y, z});
    beats_queued++;
  endfunction

  // every queued beat has come back as a result
  task automatic wait_for_drain();
    while (means_seen < beats_queued)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [LEN_W-1:0] len);
    @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    window_length_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    restart_history(len);
  endtask

  // stimulus
  initial begin : stimulus
    int           phase;
    int           count;
    int           r;
    logic [LEN_W-1:0] len;
    sample_mode_e mode;

    restart_history(LEN_W'(MAX_WINDOW));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window: rails and sign handling
    queue_beat(S_MAX, S_MIN, 16'h0000);
    queue_beat(S_MIN, S_MAX, 16'hFFFF);
    queue_beat(16'hFFFF, 16'h0001, 16'hFFFF);
    queue_beat(16'h0000, 16'h0000, 16'h0001);
    queue_beat(S_MAX, S_MAX, S_MAX);
    queue_beat(S_MIN, S_MIN, S_MIN);
    wait_for_drain();

    // zero written, taken as one
    set_window(LEN_W'(0));
    queue_beat(S_MIN, S_MAX, 16'hFFFF);
    queue_beat(16'h0001, 16'hFFFF, 16'h0000);
    wait_for_drain();

    // above the ring depth, taken as the depth
    set_window(LEN_W'(63));
    queue_beat(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(S_MAX, S_MIN, 16'h0002);
    wait_for_drain();
    set_window(LEN_W'(33));
    queue_beat(16'h0005, 16'hFFFB, 16'h0007);
    wait_for_drain();

    // short windows: pointer wrap and old samples leaving the sum
    set_window(LEN_W'(2));
    queue_beat(16'hFFFF, 16'h0000, 16'h0001);
    queue_beat(16'h0000, 16'hFFFF, 16'hFFFE);
    queue_beat(16'hFFFD, 16'h0003, S_MIN);
    queue_beat(S_MIN, S_MIN, S_MAX);
    queue_beat(S_MAX, S_MAX, S_MIN);
    wait_for_drain();
    set_window(LEN_W'(3));
    queue_beat(16'h0001, 16'h0002, 16'h0003);
    queue_beat(16'hFFF9, 16'h0008, 16'hFFF7);
    queue_beat(16'h000A, 16'hFFF5, 16'h000C);
    queue_beat(S_MIN, S_MAX, 16'h0000);
    wait_for_drain();
    set_window(LEN_W'(1));
    queue_beat(S_MAX, S_MIN, 16'hFFFF);
    queue_beat(16'hFFFE, 16'h0002, 16'h0000);
    wait_for_drain();

    // random phases, each with its own window, value mix and idling
    phase = 0;
    while (beats_queued < TARGET_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 25) len = LEN_W'($urandom_range(1, 4));
      else if (r < 40) len = LEN_W'(MAX_WINDOW);
      else if (r < 50) len = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(33, 63));
      else len = LEN_W'($urandom_range(1, MAX_WINDOW));

      r = $urandom_range(0, 99);
      if (r < 70) mode = MIX_WIDE;
      else if (r < 80) mode = RAIL_HIGH;
      else if (r < 90) mode = RAIL_LOW;
      else mode = NEAR_ZERO;

      idle_on = ($urandom_range(0, 3) != 0);
      count = (len >= 1 && len <= 4) ? $urandom_range(15, 60) : $urandom_range(20, 110);
      if (phase == 2 || phase == 9) count = $urandom_range(40, 80);

      set_window(len);
      for (int i = 0; i < count; i++)
        queue_beat(pick_sample(mode), pick_sample(mode), pick_sample(mode));
      // receiver holds off while the sender keeps offering
      if (phase == 2 || phase == 9) holds_asked++;
      wait_for_drain();
      phase++;
    end

    repeat (FINAL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: three_axis_moving_average_unit.f
rtl/tama_pkg.sv
rtl/tama_ram.sv
rtl/three_axis_moving_average_unit.sv
test/three_axis_moving_average_unit_test.sv
